### src/itfdt_pkg.sv
package itfdt_pkg;

    // Default sizes of the converter.
    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_MAX_DIGITS = 10;

    // Shift-JIS full-width digit encoding.
    localparam logic [7:0] LEAD_BYTE  = 8'h82;
    localparam logic [7:0] DIGIT_BASE = 8'h4F;
    localparam logic [7:0] TERM_BYTE  = 8'h00;

    // BCD digit constants used by the double-dabble cells.
    localparam logic [3:0] DIGIT_ZERO   = 4'd0;
    localparam logic [3:0] DIGIT_NINE   = 4'd9;
    localparam logic [3:0] ADJ_LIMIT    = 4'd5;
    localparam logic [3:0] ADJ_ADDEND   = 4'd3;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_LEAD,
        S_DIGIT,
        S_TERM
    } t_state;

    // Commands broadcast to every digit cell.
    typedef struct packed {
        logic clear;   // load zero
        logic sat;     // load nine
        logic conv;    // double-dabble step: adjust, then shift in one bit
        logic dshift;  // take the digit of the lower neighbor
    } t_cell_ctrl;

endpackage

### src/itfdt_if.sv
// Input channel: one signed value per beat.
interface itfdt_in_if #(
    parameter int VALUE_BITS = itfdt_pkg::DEF_VALUE_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// Output channel: one text byte per beat.
interface itfdt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

### src/itfdt_cell.sv
module itfdt_cell
    import itfdt_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_bit,
    input  logic [3:0] i_digit,
    output logic       o_bit,
    output logic [3:0] o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // Add three to a digit of five or more before it doubles.
    always_comb begin
        w_adj = (r_digit >= ADJ_LIMIT) ? (r_digit + ADJ_ADDEND) : r_digit;
    end

    assign o_bit   = w_adj[3];
    assign o_digit = r_digit;

    // Next digit value by command.
    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = DIGIT_ZERO;
        end else if (i_ctrl.sat) begin
            n_digit = DIGIT_NINE;
        end else if (i_ctrl.conv) begin
            n_digit = {w_adj[2:0], i_bit};
        end else if (i_ctrl.dshift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

### src/int_to_fullwidth_decimal_text.sv
// Channel | Dir | Payload                     | Beat
// i_in    | in  | value (VALUE_BITS, signed)  | one integer
// o_out   | out | text_byte (8), is_last (1)  | one Shift-JIS byte
//
// A non-negative value is accepted, then its VALUE_BITS-1 magnitude bits go through double
// dabble in the digit-cell chain. It then drops the leading zero digits in the skip
// state and emits a lead byte and a digit byte per digit, then the terminator.
// A negative value goes from the accept straight to its single terminator beat.
// Reset is synchronous and active low; it clears the controller and output valid.
// A stalled output holds the byte; a new value is taken while the terminator waits.
module int_to_fullwidth_decimal_text
    import itfdt_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    itfdt_in_if.sink       i_in,
    itfdt_out_if.source    o_out
);

    localparam int MAG_BITS = VALUE_BITS - 1;
    localparam int CNT_W    = $clog2(MAG_BITS);
    localparam int LEFT_W   = $clog2(MAX_DIGITS + 1);

    t_state              r_state;
    t_state              n_state;
    logic [MAG_BITS-1:0] r_bin;
    logic [MAG_BITS-1:0] n_bin;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic [LEFT_W-1:0]   r_left;
    logic [LEFT_W-1:0]   n_left;
    logic                r_ovf;
    logic                n_ovf;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [7:0]          r_out_byte;
    logic [7:0]          n_out_byte;
    logic                r_out_last;
    logic                n_out_last;

    t_cell_ctrl          w_ctrl;
    logic                w_accept;
    logic                w_out_free;
    logic                w_conv_done;
    logic                w_carry;
    logic [3:0]          w_top;
    logic                w_bit   [MAX_DIGITS+1];
    logic [3:0]          w_dig   [MAX_DIGITS+1];

    assign i_in.ready      = (r_state == S_IDLE);
    assign w_accept        = i_in.valid && i_in.ready;
    assign w_out_free      = !r_out_valid || o_out.ready;
    assign w_conv_done     = (r_cnt == CNT_W'(MAG_BITS - 1));
    assign o_out.valid     = r_out_valid;
    assign o_out.text_byte = r_out_byte;
    assign o_out.is_last   = r_out_last;

    // Digit cell chain, least significant digit at index zero.
    assign w_bit[0] = r_bin[MAG_BITS-1];
    assign w_dig[0] = DIGIT_ZERO;

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        itfdt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_bit   (w_bit[g]),
            .i_digit (w_dig[g]),
            .o_bit   (w_bit[g+1]),
            .o_digit (w_dig[g+1])
        );
    end

    assign w_carry = w_bit[MAX_DIGITS];
    assign w_top   = w_dig[MAX_DIGITS];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_in.value[VALUE_BITS-1] ? S_TERM : S_CONV;
                end
            end
            S_CONV: begin
                if (w_conv_done) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (!(w_top == DIGIT_ZERO && r_left > LEFT_W'(1))) begin
                    n_state = S_LEAD;
                end
            end
            S_LEAD: begin
                if (w_out_free) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (w_out_free) begin
                    n_state = (r_left == LEFT_W'(1)) ? S_TERM : S_LEAD;
                end
            end
            S_TERM: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath controls and register updates.
    always_comb begin
        w_ctrl      = '0;
        n_bin       = r_bin;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctrl.clear = 1'b1;
                    n_bin        = i_in.value[MAG_BITS-1:0];
                    n_cnt        = '0;
                    n_ovf        = 1'b0;
                end
            end
            S_CONV: begin
                // A bit leaving the top cell means more digits than cells.
                if (w_conv_done && (r_ovf || w_carry)) begin
                    w_ctrl.sat = 1'b1;
                end else begin
                    w_ctrl.conv = 1'b1;
                end
                n_ovf  = r_ovf || w_carry;
                n_bin  = {r_bin[MAG_BITS-2:0], 1'b0};
                n_cnt  = r_cnt + CNT_W'(1);
                n_left = LEFT_W'(MAX_DIGITS);
            end
            S_SKIP: begin
                if (w_top == DIGIT_ZERO && r_left > LEFT_W'(1)) begin
                    w_ctrl.dshift = 1'b1;
                    n_left        = r_left - LEFT_W'(1);
                end
            end
            S_LEAD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = LEAD_BYTE;
                    n_out_last  = 1'b0;
                end
            end
            S_DIGIT: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_byte    = DIGIT_BASE + {4'b0000, w_top};
                    n_out_last    = 1'b0;
                    w_ctrl.dshift = 1'b1;
                    n_left        = r_left - LEFT_W'(1);
                end
            end
            S_TERM: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = TERM_BYTE;
                    n_out_last  = 1'b1;
                end
            end
            default: w_ctrl = '0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_left      <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_ovf       <= n_ovf;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    // While digits are being emitted at least one remains.
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP || r_state == S_LEAD || r_state == S_DIGIT) |-> r_left != '0)
        else $error("digit counter empty while emitting");

    // The last mark only travels with the terminator byte.
    a_last_is_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> r_out_byte == TERM_BYTE)
        else $error("last mark on a byte other than the terminator");

    // A negative value goes straight to the terminator.
    a_neg_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.value[VALUE_BITS-1]) |=> r_state == S_TERM)
        else $error("negative value did not go to the terminator");

    // A lead byte is always followed by its digit byte.
    a_lead_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEAD && w_out_free) |=> r_state == S_DIGIT)
        else $error("lead byte not followed by a digit");

endmodule

### bench/int_to_fullwidth_decimal_text_tb.sv
module int_to_fullwidth_decimal_text_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itfdt_pkg::*;

    localparam int VALUE_BITS       = DEF_VALUE_BITS;
    localparam int MAX_DIGITS       = DEF_MAX_DIGITS;
    localparam int RANDOM_PER_PHASE = 62;
    localparam int PRESSURE_ITEMS   = 30;
    localparam int HOLD_CYCLES      = 600;
    localparam int DRAIN_CYCLES     = 100;
    localparam int MAX_SHOWN        = 10;
    localparam int TIMEOUT_NS       = 5_000_000;

    // One output beat as the receiver sees it.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
    } t_text_beat;

    logic i_clk;
    logic i_rst_n = 1'b0;

    itfdt_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch();
    itfdt_out_if                           out_ch();

    t_text_beat expected_text[$];
    int         mismatch_count = 0;
    int         sender_idle_pct = 0;
    int         receiver_stall_pct = 0;
    logic       hold_req;
    logic       hold_on;

    int_to_fullwidth_decimal_text #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Free-running 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // Works out the full-width text of one value and queues its beats.
    // A negative value stops at the minus sign, so only the terminator is left.
    function automatic void predict_text(input logic signed [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] magnitude;
        logic [3:0]            digits [MAX_DIGITS];
        int                    ndig;
        ndig = 0;
        magnitude = value;
        if (value < 0) begin
            expected_text.push_back(t_text_beat'{TERM_BYTE, 1'b1});
            return;
        end
        do begin
            digits[ndig] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
            ndig++;
        end while (magnitude != 0 && ndig < MAX_DIGITS);
        // Too many digits for the store: the text saturates to all nines.
        if (magnitude != 0) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                digits[i] = DIGIT_NINE;
            end
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            expected_text.push_back(t_text_beat'{LEAD_BYTE, 1'b0});
            expected_text.push_back(t_text_beat'{DIGIT_BASE + 8'(digits[i]), 1'b0});
        end
        expected_text.push_back(t_text_beat'{TERM_BYTE, 1'b1});
    endfunction

    // Draws a value with a bias toward the digit-length boundaries.
    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        int unsigned           draw;
        logic [VALUE_BITS-1:0] bits;
        logic [VALUE_BITS-1:0] decade;
        draw = $urandom_range(99);
        bits = $urandom;
        decade = 1;
        if (draw < 15) begin
            return bits;
        end
        if (draw < 25) begin
            bits[VALUE_BITS-1] = 1'b1;
            return bits;
        end
        if (draw < 40) begin
            return $urandom_range(0, 99);
        end
        if (draw < 60) begin
            // Just below, at, or just above a power of ten.
            repeat ($urandom_range(1, 9)) decade = decade * 10;
            return decade - 1 + $urandom_range(0, 2);
        end
        bits[VALUE_BITS-1] = 1'b0;
        return bits >> $urandom_range(0, VALUE_BITS - 2);
    endfunction

    // Offers one value and waits for its beat to be taken. It is called in the
    // time step of the previous acceptance, so valid has no gap unless the sender idles.
    task automatic send_value(input logic signed [VALUE_BITS-1:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_text(value);
    endtask

    // Extremes, zero, sign cases and every digit value.
    task automatic test_directed_values();
        logic signed [VALUE_BITS-1:0] values [$];
        values = {0, 1, 9, 10, 99, 100, 12345, 1234567890, 987654321,
                  999999999, 1000000000, 2147483647, 32'sh5555_5555,
                  32'sh2AAA_AAAA, -1, -10, 32'sh8000_0000, -1, 0, 7};
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        foreach (values[i]) send_value(values[i]);
    endtask

    // Random values under one idling pattern.
    task automatic test_random_values(input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (RANDOM_PER_PHASE) send_value(pick_value());
    endtask

    // The receiver holds off for a long stretch while values keep coming,
    // so the block fills up and has to stall its input.
    task automatic test_output_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_req <= 1'b1;
        repeat (PRESSURE_ITEMS) send_value(pick_value());
    endtask

    // Long receiver hold-off, counted in its own process.
    initial begin
        hold_req <= 1'b0;
        hold_on <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req <= 1'b0;
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on <= 1'b0;
            end
        end
    end

    // Receiver ready, stalling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_on) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Compares each output beat with the oldest expected one.
    always @(posedge i_clk) begin
        t_text_beat want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_text.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN) begin
                    $display("%0t: unexpected beat: text_byte %02h is_last %0b",
                             $realtime, out_ch.text_byte, out_ch.is_last);
                end
            end else begin
                want = expected_text.pop_front();
                if (out_ch.text_byte !== want.text_byte || out_ch.is_last !== want.is_last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN) begin
                        $display("%0t: beat mismatch: expected %02h/%0b, got %02h/%0b",
                                 $realtime, want.text_byte, want.is_last,
                                 out_ch.text_byte, out_ch.is_last);
                    end
                end
            end
        end
    end

    // Test sequence.
    initial begin
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_values();
        test_random_values(0, 0);
        test_random_values(85, 0);
        test_random_values(0, 85);
        test_random_values(21, 21);
        test_output_backpressure();
        in_ch.valid <= 1'b0;

        // Let every queued beat arrive, then watch for strays.
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
